// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// no dependencies; bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/sped_pkg.sv =====
// shared widths, reset values, state and command types for the spin detector
// no dependencies
`timescale 1ns / 1ps
package sped_pkg;
  localparam int AccelW    = 15;
  localparam int ThrW      = 15;
  localparam int SqW       = 30;
  localparam int TimeW     = 32;
  localparam int RootW     = 15;
  localparam int RemW      = 17;
  localparam int RootSteps = SqW / 2;
  localparam int CntW      = 4;
  localparam int AddrW     = 3;
  localparam int DataW     = 32;

  localparam logic [ThrW-1:0] StartThrRst = 15'd2000;
  localparam logic [ThrW-1:0] StopThrRst  = 15'd1300;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_Z,
    ST_MUL_START,
    ST_MUL_STOP,
    ST_DRAIN,
    ST_DECIDE,
    ST_ROOT,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_X,
    OP_Y,
    OP_Z,
    OP_START,
    OP_STOP
  } mul_op_t;

  typedef enum logic {
    REG_START_THR = 1'b0,
    REG_STOP_THR  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic    capture;
    logic    mul_en;
    mul_op_t mul_op;
    logic    decide;
    logic    root_step;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic report;
    logic out_busy;
  } dp_status_t;
endpackage

// ===== rtl/sped_sample_if.sv =====
// request channel for one acceleration sample with its timestamp
// depends on sped_pkg
`timescale 1ns / 1ps
interface sped_sample_if;
  import sped_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [AccelW-1:0] accel_x;
  logic signed [AccelW-1:0] accel_y;
  logic signed [AccelW-1:0] accel_z;
  logic [TimeW-1:0]         now_ms;
  modport source (output valid, accel_x, accel_y, accel_z, now_ms, input ready);
  modport sink (input valid, accel_x, accel_y, accel_z, now_ms, output ready);
endinterface

// ===== rtl/sped_result_if.sv =====
// result channel carrying peak magnitude and spin duration
// depends on sped_pkg
`timescale 1ns / 1ps
interface sped_result_if;
  import sped_pkg::*;
  logic             valid;
  logic             ready;
  logic [RootW-1:0] peak_magnitude_mg;
  logic [TimeW-1:0] spin_duration_ms;
  modport source (output valid, peak_magnitude_mg, spin_duration_ms, input ready);
  modport sink (input valid, peak_magnitude_mg, spin_duration_ms, output ready);
endinterface

// ===== rtl/sped_ctrl.sv =====
// sequencer for the spin detector: multiply schedule, decision, root steps
// depends on sped_pkg
`timescale 1ns / 1ps
module sped_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sped_pkg::dp_status_t  status,
  output sped_pkg::ctrl_cmd_t   cmd
);
  import sped_pkg::*;

  state_t          state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.mul_op  = OP_X;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = OP_X;
        state_nxt  = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = OP_Y;
        state_nxt  = ST_MUL_Z;
      end
      ST_MUL_Z: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = OP_Z;
        state_nxt  = ST_MUL_START;
      end
      ST_MUL_START: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = OP_START;
        state_nxt  = ST_MUL_STOP;
      end
      ST_MUL_STOP: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = OP_STOP;
        state_nxt  = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = status.report ? ST_ROOT : ST_IDLE;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CntW'(RootSteps - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end
endmodule

// ===== rtl/sped_dp.sv =====
// datapath: sample registers, shared squarer, peak hold, spin state,
// digit-by-digit square root and the output register; depends on sped_pkg
`timescale 1ns / 1ps
module sped_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sped_pkg::ctrl_cmd_t          cmd,
  output sped_pkg::dp_status_t         status,
  input  logic signed [sped_pkg::AccelW-1:0] accel_x,
  input  logic signed [sped_pkg::AccelW-1:0] accel_y,
  input  logic signed [sped_pkg::AccelW-1:0] accel_z,
  input  logic [sped_pkg::TimeW-1:0]   now_ms,
  input  logic [sped_pkg::ThrW-1:0]    start_thr,
  input  logic [sped_pkg::ThrW-1:0]    stop_thr,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sped_pkg::RootW-1:0]   out_peak,
  output logic [sped_pkg::TimeW-1:0]   out_dur
);
  import sped_pkg::*;

  localparam int ShW = RemW + 2;

  // captured sample
  logic signed [AccelW-1:0] x_r, y_r, z_r;
  logic [TimeW-1:0]         now_r;

  // squarer pipe
  logic [AccelW-1:0] raw_op;
  logic [AccelW-1:0] mul_a;
  logic [SqW-1:0]    prod_nxt;
  logic [SqW-1:0]    prod_r;
  logic              mul_vld_r;
  mul_op_t           mul_op_r;

  logic [SqW-1:0] acc_r, start_sq_r, stop_sq_r;

  // spin state
  logic             spinning_r;
  logic [TimeW-1:0] start_ms_r;
  logic [SqW-1:0]   peak_r;
  logic [SqW-1:0]   peak_nxt;
  logic             report;

  // root unit
  logic [SqW-1:0]   rad_r;
  logic [RemW-1:0]  rem_r;
  logic [RootW-1:0] root_r;
  logic [ShW-1:0]   rem_sh;
  logic [ShW-1:0]   trial;
  logic             take;

  logic             out_valid_r;
  logic [RootW-1:0] out_peak_r;
  logic [TimeW-1:0] out_dur_r;

  always_comb begin
    case (cmd.mul_op)
      OP_X:     raw_op = x_r;
      OP_Y:     raw_op = y_r;
      OP_Z:     raw_op = z_r;
      OP_START: raw_op = start_thr;
      OP_STOP:  raw_op = stop_thr;
      default:  raw_op = '0;
    endcase
  end

  // thresholds are unsigned, axis values take their magnitude
  assign mul_a = ((cmd.mul_op == OP_X || cmd.mul_op == OP_Y || cmd.mul_op == OP_Z)
                  && raw_op[AccelW-1]) ? (~raw_op + 1'b1) : raw_op;
  assign prod_nxt = SqW'(mul_a) * SqW'(mul_a);

  assign peak_nxt = (acc_r > peak_r) ? acc_r : peak_r;
  assign report   = cmd.decide && spinning_r && (acc_r < stop_sq_r);

  assign rem_sh = {rem_r, rad_r[SqW-1 -: 2]};
  assign trial  = {{(ShW - RootW - 2){1'b0}}, root_r, 2'b01};
  assign take   = (rem_sh >= trial);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r   <= 1'b0;
      spinning_r  <= 1'b0;
      start_ms_r  <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mul_vld_r <= cmd.mul_en;
      if (cmd.decide) begin
        if (report) begin
          spinning_r <= 1'b0;
          peak_r     <= '0;
        end else begin
          peak_r <= peak_nxt;
          if (!spinning_r && (acc_r > start_sq_r)) begin
            spinning_r <= 1'b1;
            start_ms_r <= now_r;
          end
        end
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r   <= accel_x;
      y_r   <= accel_y;
      z_r   <= accel_z;
      now_r <= now_ms;
    end
    if (cmd.mul_en) begin
      prod_r   <= prod_nxt;
      mul_op_r <= cmd.mul_op;
    end
    if (mul_vld_r) begin
      case (mul_op_r)
        OP_X:     acc_r      <= prod_r;
        OP_Y:     acc_r      <= acc_r + prod_r;
        OP_Z:     acc_r      <= acc_r + prod_r;
        OP_START: start_sq_r <= prod_r;
        OP_STOP:  stop_sq_r  <= prod_r;
        default:  acc_r      <= acc_r;
      endcase
    end
    if (report) begin
      rad_r  <= peak_nxt;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.root_step) begin
      rad_r <= {rad_r[SqW-3:0], 2'b00};
      if (take) begin
        rem_r  <= RemW'(rem_sh - trial);
        root_r <= {root_r[RootW-2:0], 1'b1};
      end else begin
        rem_r  <= RemW'(rem_sh);
        root_r <= {root_r[RootW-2:0], 1'b0};
      end
    end
    if (cmd.load_out) begin
      out_peak_r <= root_r;
      out_dur_r  <= now_r - start_ms_r;
    end
  end

  assign status.report   = report;
  assign status.out_busy = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign out_peak        = out_peak_r;
  assign out_dur         = out_dur_r;
endmodule

// ===== rtl/spin_event_peak_duration_detector.sv =====
// spin event detector top level: configuration registers, controller and datapath
// depends on sped_pkg, sped_sample_if, sped_result_if, sped_ctrl, sped_dp, assert_macros.svh
//
//   channel   direction  carries
//   in_if     sink       accel_x, accel_y, accel_z, now_ms
//   out_if    source     peak_magnitude_mg, spin_duration_ms
//   apb       slave      start_threshold_mg at 0x0, stop_threshold_mg at 0x4
//
// a sample that ends no spin passes through accept, five squarer passes, drain and decide
// a sample that ends a spin then runs the square-root steps, one per root bit, and the output load
// the single shared 15x15 squarer and the 2-bit-per-step root unit shape these sequences
// a waiting result holds the block in its load state only until the output slot frees
// reset is synchronous and active low; thresholds return to 2000 and 1300 mg
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spin_event_peak_duration_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  sped_sample_if.sink                   in_if,
  sped_result_if.source                 out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sped_pkg::AddrW-1:0]    paddr,
  input  logic [sped_pkg::DataW-1:0]    pwdata,
  output logic [sped_pkg::DataW-1:0]    prdata,
  output logic                          pready
);
  import sped_pkg::*;

  // threshold registers
  logic [ThrW-1:0] start_thr_r;
  logic [ThrW-1:0] stop_thr_r;
  logic            cfg_wr;
  reg_idx_t        cfg_idx;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  // word-aligned decode, low address bits ignored
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_thr_r <= StartThrRst;
      stop_thr_r  <= StopThrRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_START_THR: start_thr_r <= pwdata[ThrW-1:0];
        REG_STOP_THR:  stop_thr_r  <= pwdata[ThrW-1:0];
        default: begin
        end
      endcase
    end
  end

  // readback, zero extended
  always_comb begin
    unique case (cfg_idx)
      REG_START_THR: prdata = DataW'(start_thr_r);
      REG_STOP_THR:  prdata = DataW'(stop_thr_r);
      default:       prdata = '0;
    endcase
  end

  // sequencer: one request in flight at a time
  sped_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // squarer, peak hold, spin tracking, root unit, output register
  sped_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .accel_x   (in_if.accel_x),
    .accel_y   (in_if.accel_y),
    .accel_z   (in_if.accel_z),
    .now_ms    (in_if.now_ms),
    .start_thr (start_thr_r),
    .stop_thr  (stop_thr_r),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_peak  (out_if.peak_magnitude_mg),
    .out_dur   (out_if.spin_duration_ms)
  );

  // an accepted request is worked alone
  `ASSERT_NEXT(a_one_request_in_flight, clk, rst_n, in_if.valid && in_if.ready, !in_if.ready)
  // a report always runs the root unit before taking the next request
  `ASSERT_NEXT(a_report_runs_root, clk, rst_n, status.report, !in_if.ready && cmd.root_step)
  // a new result appears only from a controller load
  `ASSERT_IMPLIES(a_out_from_load, clk, rst_n, $rose(out_if.valid), $past(cmd.load_out))
endmodule
